@@ src/perm_unrk_pkg.sv @@
// Shared types, constants, factorial table and microcode store for permutation unranking.
package perm_unrk_pkg;

  // Field widths of the stream items.
  localparam int COUNT_W    = 5;
  localparam int RANK_W     = 62;
  localparam int POS_W      = 5;
  localparam int VAL_W      = 5;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  // A factorial-base digit is at most 19, so five quotient bits are enough.
  localparam int QUO_W = 5;
  localparam int BIT_W = 3;
  localparam logic [BIT_W-1:0] QUO_TOP = 3'd4;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_DIV,
    OP_EMIT,
    OP_EMIT_OOR
  } op_t;

  // Conditions that hold the sequencer on its current step.
  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_NO_INPUT,
    WAIT_OUT_FULL
  } wait_t;

  // Branch conditions; when false the step counter advances by one.
  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_IN_RANGE,
    JMP_MORE_BITS,
    JMP_NOT_LAST
  } jump_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_FETCH  = 3'd0;
  localparam step_t STEP_CHECK  = 3'd1;
  localparam step_t STEP_OOR    = 3'd2;
  localparam step_t STEP_DIV    = 3'd3;
  localparam step_t STEP_EMIT   = 3'd4;
  localparam step_t STEP_RETURN = 3'd5;

  typedef struct packed {
    wait_t wait_cond;
    jump_t jump_cond;
    step_t target;
    op_t   op;
  } ctrl_word_t;

  // Microcode store: one control word per step.
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    unique case (step)
      STEP_FETCH:  w = '{WAIT_NO_INPUT, JMP_NEVER,     STEP_FETCH, OP_LOAD};
      STEP_CHECK:  w = '{WAIT_NONE,     JMP_IN_RANGE,  STEP_DIV,   OP_INIT};
      STEP_OOR:    w = '{WAIT_OUT_FULL, JMP_ALWAYS,    STEP_FETCH, OP_EMIT_OOR};
      STEP_DIV:    w = '{WAIT_NONE,     JMP_MORE_BITS, STEP_DIV,   OP_DIV};
      STEP_EMIT:   w = '{WAIT_OUT_FULL, JMP_NOT_LAST,  STEP_DIV,   OP_EMIT};
      STEP_RETURN: w = '{WAIT_NONE,     JMP_ALWAYS,    STEP_FETCH, OP_NOP};
      default:     w = '{WAIT_NONE,     JMP_ALWAYS,    STEP_FETCH, OP_NOP};
    endcase
    return w;
  endfunction

  // Factorials 0! through 20!; larger arguments saturate to all ones.
  function automatic logic [RANK_W-1:0] fact(input logic [COUNT_W-1:0] m);
    logic [RANK_W-1:0] f;
    case (m)
      5'd0:    f = 62'd1;
      5'd1:    f = 62'd1;
      5'd2:    f = 62'd2;
      5'd3:    f = 62'd6;
      5'd4:    f = 62'd24;
      5'd5:    f = 62'd120;
      5'd6:    f = 62'd720;
      5'd7:    f = 62'd5040;
      5'd8:    f = 62'd40320;
      5'd9:    f = 62'd362880;
      5'd10:   f = 62'd3628800;
      5'd11:   f = 62'd39916800;
      5'd12:   f = 62'd479001600;
      5'd13:   f = 62'd6227020800;
      5'd14:   f = 62'd87178291200;
      5'd15:   f = 62'd1307674368000;
      5'd16:   f = 62'd20922789888000;
      5'd17:   f = 62'd355687428096000;
      5'd18:   f = 62'd6402373705728000;
      5'd19:   f = 62'd121645100408832000;
      5'd20:   f = 62'd2432902008176640000;
      default: f = '1;
    endcase
    return f;
  endfunction

endpackage

@@ src/permutation_unrank.sv @@
// Permutation unranking top level: microcoded sequencer over a factorial-base digit datapath.
//
//  channel   | dir | fields (lowest bit first)
//  ----------+-----+-----------------------------------------------------
//  s_axis    | in  | tdata: element_count[4:0], rank[66:5], zero pad
//  m_axis    | out | tdata: position[4:0], value[9:5], zero pad;
//            |     | tlast: last; tuser: out_of_range
//
// An item of length n in range runs one fetch, one range check, then per position five
// restoring-division steps on the shared 66-bit compare/subtract and one emit, and a final
// return step. An out-of-range item runs the fetch, range check and out-of-range emit steps.
// Reset (rst, synchronous) returns the step counter to fetch and empties the output register.
// Emit steps wait while the output register holds an item not yet taken.
module permutation_unrank
  import perm_unrk_pkg::*;
#(
  parameter int MAX_LEN = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // element_count, rank, zero pad
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // position, value, zero pad
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser    // out_of_range
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SH_W  = RANK_W + 4;
  localparam int PAD_W = OUT_DATA_W - POS_W - VAL_W;

  step_t              pc, pc_next;
  ctrl_word_t         cw;
  logic               stall;
  logic               act;
  logic               take_jump;

  logic [COUNT_W-1:0] n_reg;
  logic [RANK_W-1:0]  rem;
  logic [QUO_W-1:0]   quo;
  logic [BIT_W-1:0]   bit_cnt;
  logic [POS_W-1:0]   pos;
  logic [VAL_W-1:0]   pool [MAX_LEN];

  logic [RANK_W-1:0]  cur_fact;
  logic [RANK_W-1:0]  range_fact;
  logic               in_range;
  logic [SH_W-1:0]    shifted;
  logic               fits;
  logic [COUNT_W-1:0] avail;
  logic [QUO_W-1:0]   idx_full;
  logic [IDX_W-1:0]   idx;
  logic               is_last;

  // Control word fetch and hold conditions.
  always_comb begin
    cw = ucode(pc);
    unique case (cw.wait_cond)
      WAIT_NONE:     stall = 1'b0;
      WAIT_NO_INPUT: stall = !s_axis_tvalid;
      WAIT_OUT_FULL: stall = m_axis_tvalid && !m_axis_tready;
      default:       stall = 1'b0;
    endcase
    act = !stall;
  end

  assign s_axis_tready = (cw.wait_cond == WAIT_NO_INPUT);

  // Datapath terms: factorials, range check, one division bit, pool index.
  always_comb begin
    cur_fact   = fact(n_reg - COUNT_W'(1) - pos);
    range_fact = fact(n_reg);
    in_range   = (n_reg != '0) && (n_reg <= COUNT_W'(MAX_LEN)) && (rem < range_fact);
    shifted    = {4'b0, cur_fact} << bit_cnt;
    fits       = ({4'b0, rem} >= shifted);
    avail      = n_reg - pos;
    idx_full   = (quo >= avail) ? (avail - COUNT_W'(1)) : quo;
    idx        = idx_full[IDX_W-1:0];
    is_last    = (pos == n_reg - COUNT_W'(1));
  end

  // Branch decision and next step.
  always_comb begin
    unique case (cw.jump_cond)
      JMP_NEVER:     take_jump = 1'b0;
      JMP_ALWAYS:    take_jump = 1'b1;
      JMP_IN_RANGE:  take_jump = in_range;
      JMP_MORE_BITS: take_jump = (bit_cnt != '0);
      JMP_NOT_LAST:  take_jump = !is_last;
      default:       take_jump = 1'b0;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (take_jump) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  // Output valid flag: set by an emit, cleared when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (act && (cw.op == OP_EMIT || cw.op == OP_EMIT_OOR)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Datapath registers, driven by the current operation.
  always_ff @(posedge clk) begin
    if (act) begin
      unique case (cw.op)
        OP_NOP: begin
        end
        OP_LOAD: begin
          n_reg <= s_axis_tdata[COUNT_W-1:0];
          rem   <= s_axis_tdata[COUNT_W+RANK_W-1:COUNT_W];
        end
        OP_INIT: begin
          pos     <= '0;
          quo     <= '0;
          bit_cnt <= QUO_TOP;
          for (int j = 0; j < MAX_LEN; j++) begin
            pool[j] <= VAL_W'(j);
          end
        end
        OP_DIV: begin
          if (fits) begin
            rem          <= rem - shifted[RANK_W-1:0];
            quo[bit_cnt] <= 1'b1;
          end
          bit_cnt <= bit_cnt - BIT_W'(1);
        end
        OP_EMIT: begin
          m_axis_tdata <= {{PAD_W{1'b0}}, pool[idx], pos};
          m_axis_tlast <= is_last;
          m_axis_tuser <= 1'b0;
          pos          <= pos + POS_W'(1);
          quo          <= '0;
          bit_cnt      <= QUO_TOP;
          // Remove the chosen entry by closing the gap above it.
          for (int j = 0; j < MAX_LEN - 1; j++) begin
            if (IDX_W'(j) >= idx) begin
              pool[j] <= pool[j+1];
            end
          end
        end
        OP_EMIT_OOR: begin
          m_axis_tdata <= '0;
          m_axis_tlast <= 1'b1;
          m_axis_tuser <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The digit found by the division must select an entry still in the pool.
  a_digit_in_pool: assert property (@(posedge clk) disable iff (rst)
    (act && cw.op == OP_EMIT) |-> (quo < avail))
    else $error("digit exceeds the number of unused values");

  // Division steps only run for positions inside the permutation.
  a_pos_in_length: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_DIV) |-> (pos < n_reg))
    else $error("division step past the last position");

  // An out-of-range item is always a single, final item.
  a_oor_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("out-of-range item without last");

  // An emit never overwrites an item that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending output item overwritten");

  // The bit counter never leaves the quotient range.
  a_bit_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_DIV) |-> (bit_cnt <= QUO_TOP))
    else $error("division bit counter out of range");

endmodule
